// ----- design/tce_pkg.sv -----
// Package for the text console engine: geometry, request codes, payload types, states.
package tce_pkg;

  localparam int unsigned Columns = 80;
  localparam int unsigned Rows = 25;
  localparam int unsigned Cells = Rows * Columns;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned RowW = 5;
  localparam int unsigned ColW = 7;
  localparam logic [7:0] DefaultAttrReset = 8'h07;
  localparam logic [7:0] SpaceChar = 8'h20;

  localparam logic [3:0] ReqSetMode = 4'd0;
  localparam logic [3:0] ReqShape = 4'd1;
  localparam logic [3:0] ReqSetCursor = 4'd2;
  localparam logic [3:0] ReqGetCursor = 4'd3;
  localparam logic [3:0] ReqPage = 4'd4;
  localparam logic [3:0] ReqScrollUp = 4'd5;
  localparam logic [3:0] ReqScrollDown = 4'd6;
  localparam logic [3:0] ReqRead = 4'd7;
  localparam logic [3:0] ReqWriteCa = 4'd8;
  localparam logic [3:0] ReqWriteCh = 4'd9;
  localparam logic [3:0] ReqTeletype = 4'd10;
  localparam logic [3:0] ReqGetMode = 4'd11;

  localparam logic [7:0] ChBell = 8'h07;
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLineFeed = 8'h0A;
  localparam logic [7:0] ChReturn = 8'h0D;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [7:0]  value_byte;
    logic [7:0]  fill_attr;
    logic [7:0]  char_attr;
    logic [7:0]  top_or_shape_start;
    logic [7:0]  left_or_shape_end;
    logic [7:0]  bottom_or_row;
    logic [7:0]  right_or_col;
    logic [15:0] repeat_count;
  } req_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] read_attr;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [4:0] shape_start;
    logic [4:0] shape_end;
    logic [7:0] mode_value;
    logic [7:0] page_value;
    logic [7:0] column_count;
  } rsp_t;

  typedef enum logic [3:0] {
    StClear,     // reset clearing pass
    StIdle,
    StDecode,
    StFill,      // write constant cell over a range
    StMoveRd,    // window move: read source cell
    StMoveWr,    // window move: write destination cell
    StCellRd,    // read the cursor cell
    StCellWr,    // write the cursor cell
    StRespond
  } state_e;

endpackage

// ----- design/text_console_engine.sv -----
// Text console engine: cell buffer, cursor and sequencer for video service requests.
// Set mode blanks the whole screen; a window scroll up moves the kept cells, then blanks
// the vacated lines; a teletype write at the last cell also scrolls the screen up one line.
// One transaction at a time; in_stall_o is high until the cycle after the result is taken.
// Reset clears control state, then a clearing pass zeroes the buffer.
module text_console_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tce_pkg::req_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tce_pkg::rsp_t     out_data_o
);

  localparam int unsigned AW = tce_pkg::AddrW;
  localparam logic [AW-1:0] ColsA = AW'(tce_pkg::Columns);
  localparam logic [AW-1:0] LastA = AW'(tce_pkg::Cells - 1);
  localparam logic [7:0] LastRow = 8'(tce_pkg::Rows - 1);
  localparam logic [7:0] LastCol = 8'(tce_pkg::Columns - 1);

  tce_pkg::state_e state_q, state_d;
  tce_pkg::req_t   req_q;
  logic [7:0] dattr_q;
  logic [tce_pkg::RowW-1:0] row_q, row_d;
  logic [tce_pkg::ColW-1:0] col_q, col_d;
  logic [4:0] shs_q, shs_d, she_q, she_d;
  logic [7:0] mode_q, mode_d, page_q, page_d;
  logic [7:0] rch_q, rch_d, rat_q, rat_d;

  // Sweep registers: current address, row/column inside the window.
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] rowbase_q, rowbase_d;
  logic [7:0] x_q, x_d, y_q, y_d;
  logic [7:0] left_q, left_d, right_q, right_d, yend_q, yend_d, bot_q, bot_d;
  logic [AW-1:0] off_q, off_d;    // lines * columns
  logic [15:0] fill_q, fill_d;
  logic scroll_q, scroll_d;       // teletype scroll pending after the cell write

  // Single-port buffer.
  logic [15:0] mem [tce_pkg::Cells];
  logic [15:0] rdata_q;
  logic        we;
  logic [AW-1:0] maddr;
  logic [15:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[maddr] <= wdata;
    end
    rdata_q <= mem[maddr];
  end

  // Window clipping from the captured request.
  logic [7:0] w_bot, w_right, w_height, w_lines;
  logic       w_empty;
  always_comb begin
    w_bot = (req_q.bottom_or_row > LastRow) ? LastRow : req_q.bottom_or_row;
    w_right = (req_q.right_or_col > LastCol) ? LastCol : req_q.right_or_col;
    w_empty = (req_q.top_or_shape_start > w_bot) || (req_q.left_or_shape_end > w_right);
    w_height = w_bot - req_q.top_or_shape_start + 8'd1;
    w_lines = (req_q.value_byte == 8'd0 || req_q.value_byte > w_height) ?
              w_height : req_q.value_byte;
  end

  logic [AW-1:0] cur_addr;
  assign cur_addr = AW'(row_q) * ColsA + AW'(col_q);

  logic [7:0] tab_col;
  assign tab_col = (8'(col_q) + 8'd8) & ~8'd7;

  // Next state and datapath.
  always_comb begin
    state_d = state_q;
    row_d = row_q; col_d = col_q; shs_d = shs_q; she_d = she_q;
    mode_d = mode_q; page_d = page_q; rch_d = rch_q; rat_d = rat_q;
    addr_d = addr_q; rowbase_d = rowbase_q; x_d = x_q; y_d = y_q;
    left_d = left_q; right_d = right_q; yend_d = yend_q; bot_d = bot_q;
    off_d = off_q; fill_d = fill_q; scroll_d = scroll_q;
    unique case (state_q)
      tce_pkg::StClear: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == LastA) state_d = tce_pkg::StIdle;
      end
      tce_pkg::StIdle: begin
        if (in_valid_i) state_d = tce_pkg::StDecode;
      end
      tce_pkg::StDecode: begin
        rch_d = 8'd0; rat_d = 8'd0;
        scroll_d = 1'b0;
        state_d = tce_pkg::StRespond;
        unique case (req_q.req_type)
          tce_pkg::ReqSetMode: begin
            mode_d = req_q.value_byte;
            row_d = '0; col_d = '0;
            fill_d = {dattr_q, tce_pkg::SpaceChar};
            left_d = 8'd0; right_d = LastCol; x_d = 8'd0;
            y_d = 8'd0; bot_d = LastRow; rowbase_d = '0; addr_d = '0;
            state_d = tce_pkg::StFill;
          end
          tce_pkg::ReqShape: begin
            shs_d = req_q.top_or_shape_start[4:0];
            she_d = req_q.left_or_shape_end[4:0];
          end
          tce_pkg::ReqSetCursor: begin
            row_d = tce_pkg::RowW'((req_q.bottom_or_row > LastRow) ?
                                   LastRow : req_q.bottom_or_row);
            col_d = tce_pkg::ColW'((req_q.right_or_col > LastCol) ?
                                   LastCol : req_q.right_or_col);
          end
          tce_pkg::ReqPage: page_d = req_q.value_byte;
          tce_pkg::ReqScrollUp, tce_pkg::ReqScrollDown: begin
            if (!w_empty && (req_q.value_byte == 8'd0 ||
                             req_q.req_type == tce_pkg::ReqScrollUp)) begin
              fill_d = {req_q.fill_attr, tce_pkg::SpaceChar};
              left_d = req_q.left_or_shape_end; right_d = w_right;
              x_d = req_q.left_or_shape_end;
              y_d = req_q.top_or_shape_start;
              bot_d = w_bot;
              rowbase_d = AW'(req_q.top_or_shape_start) * ColsA;
              addr_d = AW'(req_q.top_or_shape_start) * ColsA +
                       AW'(req_q.left_or_shape_end);
              off_d = AW'(w_lines) * ColsA;
              yend_d = w_bot - w_lines; // last destination row of the move
              if (w_lines == w_height) begin
                state_d = tce_pkg::StFill;
              end else begin
                state_d = tce_pkg::StMoveRd;
              end
            end
          end
          tce_pkg::ReqRead, tce_pkg::ReqWriteCh: begin
            addr_d = cur_addr;
            if (req_q.req_type == tce_pkg::ReqRead || req_q.repeat_count != 16'd0)
              state_d = tce_pkg::StCellRd;
          end
          tce_pkg::ReqWriteCa: begin
            addr_d = cur_addr;
            fill_d = {req_q.char_attr, req_q.value_byte};
            if (req_q.repeat_count != 16'd0) state_d = tce_pkg::StCellWr;
          end
          tce_pkg::ReqTeletype: begin
            unique case (req_q.value_byte)
              tce_pkg::ChBell: ;
              tce_pkg::ChBackspace: if (col_q != '0) col_d = col_q - tce_pkg::ColW'(1);
              tce_pkg::ChTab: begin
                if (tab_col > LastCol) begin
                  col_d = '0;
                  if (8'(row_q) < LastRow) row_d = row_q + tce_pkg::RowW'(1);
                end else begin
                  col_d = tce_pkg::ColW'(tab_col);
                end
              end
              tce_pkg::ChLineFeed:
                if (8'(row_q) < LastRow) row_d = row_q + tce_pkg::RowW'(1);
              tce_pkg::ChReturn: col_d = '0;
              default: begin
                addr_d = cur_addr;
                fill_d = {dattr_q, req_q.value_byte};
                state_d = tce_pkg::StCellWr;
                if (8'(col_q) == LastCol) begin
                  col_d = '0;
                  if (8'(row_q) == LastRow) scroll_d = 1'b1;
                  else row_d = row_q + tce_pkg::RowW'(1);
                end else begin
                  col_d = col_q + tce_pkg::ColW'(1);
                end
              end
            endcase
          end
          default: ;
        endcase
      end
      tce_pkg::StMoveRd: begin
        addr_d = addr_q + off_q;
        state_d = tce_pkg::StMoveWr;
      end
      tce_pkg::StMoveWr: begin
        // Write back at destination; step to next cell.
        state_d = tce_pkg::StMoveRd;
        if (x_q == right_q) begin
          x_d = left_q;
          y_d = y_q + 8'd1;
          rowbase_d = rowbase_q + ColsA;
          addr_d = rowbase_q + ColsA + AW'(left_q);
          if (y_q == yend_q) state_d = tce_pkg::StFill;
        end else begin
          x_d = x_q + 8'd1;
          addr_d = addr_q - off_q + AW'(1);
        end
      end
      tce_pkg::StFill: begin
        if (x_q == right_q) begin
          x_d = left_q;
          y_d = y_q + 8'd1;
          rowbase_d = rowbase_q + ColsA;
          addr_d = rowbase_q + ColsA + AW'(left_q);
          if (y_q == bot_q) state_d = tce_pkg::StRespond;
        end else begin
          x_d = x_q + 8'd1;
          addr_d = addr_q + AW'(1);
        end
      end
      tce_pkg::StCellRd: begin
        if (req_q.req_type == tce_pkg::ReqRead) begin
          state_d = tce_pkg::StRespond;
          rch_d = rdata_q[7:0]; rat_d = rdata_q[15:8];
        end else begin
          fill_d = {rdata_q[15:8], req_q.value_byte};
          state_d = tce_pkg::StCellWr;
        end
      end
      tce_pkg::StCellWr: begin
        state_d = tce_pkg::StRespond;
        if (scroll_q) begin
          // Whole-screen scroll by one line.
          scroll_d = 1'b0;
          left_d = 8'd0; right_d = LastCol; x_d = 8'd0; y_d = 8'd0;
          bot_d = LastRow; yend_d = LastRow - 8'd1;
          rowbase_d = '0; addr_d = '0; off_d = ColsA;
          fill_d = {dattr_q, tce_pkg::SpaceChar};
          state_d = tce_pkg::StMoveRd;
        end
      end
      tce_pkg::StRespond: begin
        if (!out_stall_i) state_d = tce_pkg::StIdle;
      end
      default: state_d = tce_pkg::StIdle;
    endcase
  end

  // Memory port control. The cursor cell is fetched during decode and a move
  // reads its source cell in the cycle before it writes the destination.
  always_comb begin
    we = 1'b0;
    maddr = addr_q;
    wdata = fill_q;
    unique case (state_q)
      tce_pkg::StClear: begin we = 1'b1; wdata = '0; end
      tce_pkg::StDecode: maddr = cur_addr;
      tce_pkg::StFill, tce_pkg::StCellWr: we = 1'b1;
      tce_pkg::StMoveRd: maddr = addr_q + off_q;
      tce_pkg::StMoveWr: begin we = 1'b1; maddr = addr_q - off_q; wdata = rdata_q; end
      default: ;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall_o = (state_q != tce_pkg::StIdle);
    out_valid_o = (state_q == tce_pkg::StRespond);
    out_data_o.read_char = rch_q;
    out_data_o.read_attr = rat_q;
    out_data_o.cursor_row = row_q;
    out_data_o.cursor_col = col_q;
    out_data_o.shape_start = shs_q;
    out_data_o.shape_end = she_q;
    out_data_o.mode_value = mode_q;
    out_data_o.page_value = page_q;
    out_data_o.column_count = 8'(tce_pkg::Columns);
  end

  // Control and architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tce_pkg::StClear;
      dattr_q <= tce_pkg::DefaultAttrReset;
      row_q <= '0; col_q <= '0; shs_q <= '0; she_q <= '0;
      mode_q <= '0; page_q <= '0;
      addr_q <= '0; scroll_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) dattr_q <= cfg_wdata_i;
      row_q <= row_d; col_q <= col_d; shs_q <= shs_d; she_q <= she_d;
      mode_q <= mode_d; page_q <= page_d;
      addr_q <= addr_d; scroll_q <= scroll_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == tce_pkg::StIdle && in_valid_i) req_q <= in_data_i;
    rch_q <= rch_d; rat_q <= rat_d;
    rowbase_q <= rowbase_d; x_q <= x_d; y_q <= y_d;
    left_q <= left_d; right_q <= right_d; yend_q <= yend_d; bot_q <= bot_d;
    off_q <= off_d; fill_q <= fill_d;
  end

endmodule
